[rtl/sdsm_pkg.sv]
// ----------------------------------------------------------------------------
// Speed display package
// Shared types, constants and the segment decode for the speed display driver.
// ----------------------------------------------------------------------------
package sdsm_pkg;

  localparam int DIGITS_DEF = 4;
  localparam int MAX_SLOTS  = 4;
  localparam int SLOT_W     = 2;
  localparam int VAL_W      = 14;
  localparam int QUOT_W     = 10;

  localparam logic [15:0] SHOW_LIMIT = 16'd9999;
  // Reciprocal of ten in 19 fractional bits; exact for values below 43699.
  localparam logic [15:0] RECIP_TEN  = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [1:0] MODE_FALL   = 2'd0;
  localparam logic [1:0] MODE_RISE   = 2'd1;
  localparam logic [1:0] MODE_FOLLOW = 2'd2;
  localparam logic [1:0] MODE_TARGET = 2'd3;

  typedef struct packed {
    logic [15:0] measured_speed;
    logic [15:0] target_speed;
    logic        running;
    logic [1:0]  ramp_mode;
    logic        show_target;
    logic        blank;
  } in_word_t;

  typedef struct packed {
    logic [3:0] digit_enable;
    logic [6:0] segment_off;
    logic       segments_valid;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_BLANK,
    ST_DIV,
    ST_DIGIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic load_blank;
    logic do_div;
    logic load_digit;
  } cmd_t;

  typedef struct packed {
    logic blank;
    logic over_limit;
    logic last_digit;
    logic out_free;
  } status_t;

  // Active-high segment-off pattern, bit 0 is segment A.
  function automatic logic [6:0] seg_off(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h40;
      4'd1:    s = 7'h79;
      4'd2:    s = 7'h24;
      4'd3:    s = 7'h30;
      4'd4:    s = 7'h19;
      4'd5:    s = 7'h12;
      4'd6:    s = 7'h02;
      4'd7:    s = 7'h78;
      4'd8:    s = 7'h00;
      4'd9:    s = 7'h10;
      default: s = 7'h7F;
    endcase
    return s;
  endfunction

endpackage

[rtl/sdsm_ctrl.sv]
// ----------------------------------------------------------------------------
// Speed display controller
// Sequences capture, value selection and per-digit conversion and output.
// ----------------------------------------------------------------------------
module sdsm_ctrl
  import sdsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SEL;
        end
      end
      ST_SEL: begin
        if (status.blank) begin
          state_next = ST_BLANK;
        end else begin
          cmd.update = 1'b1;
          state_next = status.over_limit ? ST_IDLE : ST_DIV;
        end
      end
      ST_BLANK: begin
        if (status.out_free) begin
          cmd.load_blank = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.do_div = 1'b1;
        state_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (status.out_free) begin
          cmd.load_digit = 1'b1;
          state_next     = status.last_digit ? ST_IDLE : ST_DIV;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/sdsm_datapath.sv]
// ----------------------------------------------------------------------------
// Speed display datapath
// Holds the shown and tracked values, splits the value into decimal digits
// and drives the output register.
// ----------------------------------------------------------------------------
module sdsm_datapath
  import sdsm_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
)(
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_data,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int SLOTS = (DIGITS > MAX_SLOTS) ? MAX_SLOTS : ((DIGITS < 1) ? 1 : DIGITS);
  localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(SLOTS - 1);

  in_word_t          item;
  logic [15:0]       shown_value;
  logic [15:0]       tracked_value;
  logic [15:0]       shown_next;
  logic [15:0]       tracked_next;
  logic [VAL_W-1:0]  value;
  logic [QUOT_W-1:0] quot;
  logic [SLOT_W-1:0] slot;
  logic [29:0]       product;
  logic [VAL_W-1:0]  rem_full;
  logic [3:0]        digit;
  logic              fin;

  // Value selection for the captured word.
  always_comb begin
    tracked_next = tracked_value;
    shown_next   = shown_value;
    if (!item.running || item.ramp_mode == MODE_TARGET) begin
      shown_next = item.target_speed;
    end else if (item.ramp_mode == MODE_RISE) begin
      if (item.measured_speed > tracked_value) tracked_next = item.measured_speed;
      shown_next = tracked_next;
    end else if (item.ramp_mode == MODE_FALL) begin
      if (item.measured_speed < tracked_value) tracked_next = item.measured_speed;
      shown_next = tracked_next;
    end else begin
      tracked_next = item.measured_speed;
    end
    if (item.show_target) shown_next = item.target_speed;
  end

  assign product  = {16'd0, value} * {14'd0, RECIP_TEN};
  // Quotient is registered, so this is a shift-add and a subtract.
  assign rem_full = value - ({4'd0, quot} * VAL_W'(10));
  assign digit    = rem_full[3:0];
  assign fin      = (quot == '0) || (slot == TOP_SLOT);

  assign status.blank      = item.blank;
  assign status.over_limit = (shown_next >= SHOW_LIMIT);
  assign status.last_digit = fin;
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_value   <= '0;
      tracked_value <= '0;
    end else if (cmd.update) begin
      shown_value   <= shown_next;
      tracked_value <= tracked_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_data;
    if (cmd.update) begin
      value <= shown_next[VAL_W-1:0];
      slot  <= '0;
    end else if (cmd.load_digit) begin
      value <= {4'd0, quot};
      slot  <= slot + 1'b1;
    end
    if (cmd.do_div) quot <= product[RECIP_SHIFT +: QUOT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_blank || cmd.load_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_blank) begin
      out_data <= '{digit_enable: 4'd0, segment_off: 7'd0, segments_valid: 1'b0,
                    last: 1'b1};
    end else if (cmd.load_digit) begin
      out_data <= '{digit_enable: 4'b0001 << (TOP_SLOT - slot), segment_off: seg_off(digit),
                    segments_valid: 1'b1, last: fin};
    end
  end

endmodule

[rtl/speed_display_seven_segment_mux_top.sv]
// ----------------------------------------------------------------------------
// Speed display seven-segment driver, top level
// Picks the speed to show and emits it one digit per word, units first.
// ----------------------------------------------------------------------------
// Flow: a word is taken in idle and the value to show is selected; each digit
// then passes a reciprocal multiply and a remainder and output load, which
// waits for a free output register. A new word is taken only after the last
// one is done, since the divide-by-ten step is shared; a blank word skips it.
// Reset: synchronous, clears the shown and tracked values to zero and
// empties the output register.
module speed_display_seven_segment_mux_top
  import sdsm_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  cmd_t    cmd;
  status_t status;

  sdsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sdsm_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/sdsm_checker.sv]
// ----------------------------------------------------------------------------
// Speed display port checker
// Watches the top-level ports for output word consistency and busy behavior.
// ----------------------------------------------------------------------------
module sdsm_checker
  import sdsm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input out_word_t out_data,
  input logic      out_valid,
  input logic      out_stall
);

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // The block is busy in the cycle after it takes a word.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // A blank word is a single, final word with everything off.
  a_blank_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.segments_valid |->
      out_data.last && out_data.digit_enable == 4'd0 && out_data.segment_off == 7'd0)
    else $error("malformed blank word");

  // A digit word drives exactly one digit.
  a_digit_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.segments_valid |-> $onehot(out_data.digit_enable))
    else $error("digit enable not one-hot");

endmodule

bind speed_display_seven_segment_mux_top sdsm_checker u_sdsm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Speed display driver testbench
// Drives refresh words through a short table of directed cases and then random
// traffic. An in-file model of the speed selection and digit split predicts
// the words of random traffic and of rows marked -1. Both sides idle and stall
// at random; the output side holds off once, long enough to fill the block.
// ----------------------------------------------------------------------------
module tb;
  import sdsm_pkg::*;

  localparam int SLOTS = (DIGITS_DEF > MAX_SLOTS) ? MAX_SLOTS : DIGITS_DEF;
  localparam int RAND_WORDS = 138;
  localparam int HOLD_CYCLES = 80;

  // Segment-off patterns for the decimal digits, segment A in bit 0.
  localparam logic [6:0] SEG_PATTERN [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  speed_display_seven_segment_mux_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  logic [15:0] shown_spd;
  logic [15:0] tracked_spd;
  out_word_t   pending_digits[$];
  out_word_t   want;
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_req;

  // Directed table: a count of -1 means the row is checked by the predictor.
  in_word_t  row_in[$];
  int        row_count[$];
  int        row_first[$];
  out_word_t row_words[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

  function automatic in_word_t mk_in(input logic [15:0] meas, input logic [15:0] targ,
                                     input logic run, input logic [1:0] mode,
                                     input logic show, input logic blk);
    in_word_t w;
    w.measured_speed = meas;
    w.target_speed   = targ;
    w.running        = run;
    w.ramp_mode      = mode;
    w.show_target    = show;
    w.blank          = blk;
    return w;
  endfunction

  function automatic out_word_t mk_digit(input logic [3:0] en, input logic [6:0] seg,
                                         input logic fin);
    out_word_t r;
    r.digit_enable   = en;
    r.segment_off    = seg;
    r.segments_valid = 1'b1;
    r.last           = fin;
    return r;
  endfunction

  function automatic void add_row(input in_word_t w, input int n,
                                  input out_word_t e0 = '0, input out_word_t e1 = '0,
                                  input out_word_t e2 = '0, input out_word_t e3 = '0);
    row_in.push_back(w);
    row_count.push_back(n);
    row_first.push_back(row_words.size());
    if (n > 0) row_words.push_back(e0);
    if (n > 1) row_words.push_back(e1);
    if (n > 2) row_words.push_back(e2);
    if (n > 3) row_words.push_back(e3);
  endfunction

  // Updates the selection state and, if keep is set, queues the digit words.
  function automatic void predict_display(input in_word_t w, input bit keep);
    logic [15:0] v;
    logic [3:0]  d;
    out_word_t   r;
    bit          fin;
    if (w.blank) begin
      r = '0;
      r.last = 1'b1;
      if (keep) pending_digits.push_back(r);
      return;
    end
    if (!w.running || w.ramp_mode == MODE_TARGET) begin
      shown_spd = w.target_speed;
    end else if (w.ramp_mode == MODE_RISE) begin
      if (w.measured_speed > tracked_spd) tracked_spd = w.measured_speed;
      shown_spd = tracked_spd;
    end else if (w.ramp_mode == MODE_FALL) begin
      if (w.measured_speed < tracked_spd) tracked_spd = w.measured_speed;
      shown_spd = tracked_spd;
    end else begin
      tracked_spd = w.measured_speed;
    end
    if (w.show_target) shown_spd = w.target_speed;
    if (shown_spd >= SHOW_LIMIT) return;
    v = shown_spd;
    for (int i = 0; i < SLOTS; i++) begin
      d   = 4'(v % 10);
      v   = v / 10;
      fin = (v == 0) || (i == SLOTS - 1);
      r   = mk_digit(4'(1 << (SLOTS - 1 - i)), SEG_PATTERN[d], fin);
      if (keep) pending_digits.push_back(r);
      if (fin) break;
    end
  endfunction

  // Offers one refresh word and queues its digit words once it is taken.
  task automatic send_word(input in_word_t w, input int typed_n, input int typed_first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_display(w, typed_n < 0);
    for (int k = 0; k < typed_n; k++) pending_digits.push_back(row_words[typed_first + k]);
  endtask

  function automatic logic [15:0] rand_speed();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 16'($urandom_range(99));
    if (pick < 70) return 16'($urandom_range(9998, 100));
    if (pick < 85) return 16'($urandom_range(12000, 9999));
    return 16'($urandom_range(65535));
  endfunction

  // Output side: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected word, expected none, got en=%h seg=%h vld=%b last=%b",
                 $time, out_data.digit_enable, out_data.segment_off,
                 out_data.segments_valid, out_data.last);
        errors++;
      end else begin
        want = pending_digits.pop_front();
        if (out_data.digit_enable !== want.digit_enable ||
            out_data.segment_off !== want.segment_off ||
            out_data.segments_valid !== want.segments_valid ||
            out_data.last !== want.last) begin
          $display("%0t: mismatch exp en=%h seg=%h v=%b l=%b got en=%h seg=%h v=%b l=%b",
                   $time, want.digit_enable, want.segment_off, want.segments_valid, want.last,
                   out_data.digit_enable, out_data.segment_off,
                   out_data.segments_valid, out_data.last);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    in_word_t    w;
    logic [1:0]  cur_mode;
    logic [15:0] last_meas;
    errors        = 0;
    shown_spd     = '0;
    tracked_spd   = '0;
    send_idle_pct = 35;
    recv_idle_pct = 72;
    hold_req      = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    rst           = 1'b1;
    cur_mode      = MODE_FOLLOW;
    last_meas     = '0;

    // Right after reset the follow mode keeps the cleared shown value.
    add_row(mk_in(16'd123, 16'd77, 1'b1, MODE_FOLLOW, 1'b0, 1'b0), 1,
            mk_digit(4'b1000, 7'h40, 1'b1));
    add_row(mk_in(16'd100, 16'd0, 1'b1, MODE_RISE, 1'b0, 1'b0), -1);
    add_row(mk_in(16'hFFFF, 16'hFFFF, 1'b1, MODE_TARGET, 1'b1, 1'b1), 1,
            '{digit_enable: 4'd0, segment_off: 7'd0, segments_valid: 1'b0, last: 1'b1});
    add_row(mk_in(16'd0, 16'd9999, 1'b0, MODE_FALL, 1'b0, 1'b0), 0);
    add_row(mk_in(16'd0, 16'hFFFF, 1'b0, MODE_RISE, 1'b0, 1'b0), 0);
    add_row(mk_in(16'd0, 16'd9998, 1'b0, MODE_FOLLOW, 1'b0, 1'b0), 4,
            mk_digit(4'b1000, 7'h00, 1'b0), mk_digit(4'b0100, 7'h10, 1'b0),
            mk_digit(4'b0010, 7'h10, 1'b0), mk_digit(4'b0001, 7'h10, 1'b1));
    add_row(mk_in(16'hFFFF, 16'd3, 1'b1, MODE_FOLLOW, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd500, 16'd0, 1'b1, MODE_FALL, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd800, 16'd0, 1'b1, MODE_FALL, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd7, 16'd0, 1'b1, MODE_RISE, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd6780, 16'd0, 1'b1, MODE_RISE, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd0, 16'd1234, 1'b1, MODE_TARGET, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd9000, 16'd90, 1'b1, MODE_RISE, 1'b1, 1'b0), -1);
    add_row(mk_in(16'd0, 16'd5, 1'b0, MODE_RISE, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd10, 16'd0, 1'b1, MODE_FOLLOW, 1'b0, 1'b0), -1);
    add_row(mk_in(16'hFFFF, 16'd0, 1'b1, MODE_FALL, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd3, 16'd0, 1'b1, MODE_FALL, 1'b1, 1'b0), -1);
    add_row(mk_in(16'hFFFF, 16'd0, 1'b1, MODE_RISE, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd9999, 16'd0, 1'b1, MODE_FALL, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd9998, 16'd0, 1'b1, MODE_FALL, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd0, 16'd1000, 1'b0, MODE_FALL, 1'b0, 1'b0), -1);
    add_row(mk_in(16'd0, 16'd0, 1'b0, MODE_FALL, 1'b0, 1'b1), 1,
            '{digit_enable: 4'd0, segment_off: 7'd0, segments_valid: 1'b0, last: 1'b1});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < row_in.size(); i++) send_word(row_in[i], row_count[i], row_first[i]);

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == RAND_WORDS / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 35;
      end else if (n == 2 * RAND_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= 1'b1;
      end
      // Modes mostly persist so the trackers see ramps, not just single steps.
      if ($urandom_range(99) < 20) cur_mode = 2'($urandom_range(3));
      if ($urandom_range(99) < 50)
        last_meas = last_meas + 16'($urandom_range(600)) - 16'd300;
      else
        last_meas = rand_speed();
      w = mk_in(last_meas, rand_speed(), ($urandom_range(99) < 85), cur_mode,
                ($urandom_range(99) < 20), ($urandom_range(99) < 8));
      send_word(w, -1, 0);
    end
    in_valid <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
